### rtl/btda_pkg.sv
package btda_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DST_ENABLE  = 3'd0,
    CFG_START_MONTH = 3'd1,
    CFG_START_DAY   = 3'd2,
    CFG_END_MONTH   = 3'd3,
    CFG_END_DAY     = 3'd4
  } cfg_idx_e;

  localparam logic [11:0] YearBase      = 12'd2000;
  localparam logic [7:0]  HoursPerDay   = 8'd24;
  localparam logic [7:0]  DaysPerWeek   = 8'd7;
  localparam logic [7:0]  MonthsPerYear = 8'd12;
  localparam logic [7:0]  CenturyYear   = 8'd100;

  localparam logic [7:0] MonthFeb = 8'd2;
  localparam logic [7:0] MonthApr = 8'd4;
  localparam logic [7:0] MonthJun = 8'd6;
  localparam logic [7:0] MonthSep = 8'd9;
  localparam logic [7:0] MonthNov = 8'd11;

  localparam logic [7:0] DaysLong  = 8'd31;
  localparam logic [7:0] DaysShort = 8'd30;
  localparam logic [7:0] DaysLeap  = 8'd29;
  localparam logic [7:0] DaysFeb   = 8'd28;

  localparam logic        RstDstEnable  = 1'b0;
  localparam logic [3:0]  RstStartMonth = 4'd3;
  localparam logic [4:0]  RstStartDay   = 5'd10;
  localparam logic [3:0]  RstEndMonth   = 4'd11;
  localparam logic [4:0]  RstEndDay     = 5'd3;

  typedef struct packed {
    logic       dst_enable;
    logic [3:0] start_month;
    logic [4:0] start_day;
    logic [3:0] end_month;
    logic [4:0] end_day;
  } cfg_t;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] weekday;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } bcd_t;

  typedef struct packed {
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  weekday;
    logic [7:0]  day_of_month;
    logic [7:0]  month;
    logic [11:0] year;
  } time_t;

  // high nibble times ten plus low nibble, no digit check
  function automatic logic [7:0] bcd_to_bin(logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0000, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
  endfunction

  // yd is the decoded two-digit year; full year is 2000 + yd, so only
  // 2000 and 2100 are centuries, and only 2000 is a multiple of 400
  function automatic logic [7:0] month_len(logic [7:0] yd, logic [7:0] mo);
    logic leap;
    leap = (yd[1:0] == 2'b00) && (yd != CenturyYear);
    if (mo == MonthFeb) begin
      return leap ? DaysLeap : DaysFeb;
    end else if (mo == MonthApr || mo == MonthJun || mo == MonthSep || mo == MonthNov) begin
      return DaysShort;
    end
    return DaysLong;
  endfunction

endpackage

### rtl/btda_cfg_regs.sv
module btda_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [btda_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [btda_pkg::CfgDataW-1:0] cfg_wdata_i,
  output btda_pkg::cfg_t               cfg_o
);

  btda_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        btda_pkg::CFG_DST_ENABLE:  cfg_d.dst_enable  = cfg_wdata_i[0];
        btda_pkg::CFG_START_MONTH: cfg_d.start_month = cfg_wdata_i[3:0];
        btda_pkg::CFG_START_DAY:   cfg_d.start_day   = cfg_wdata_i[4:0];
        btda_pkg::CFG_END_MONTH:   cfg_d.end_month   = cfg_wdata_i[3:0];
        btda_pkg::CFG_END_DAY:     cfg_d.end_day     = cfg_wdata_i[4:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dst_enable  <= btda_pkg::RstDstEnable;
      cfg_q.start_month <= btda_pkg::RstStartMonth;
      cfg_q.start_day   <= btda_pkg::RstStartDay;
      cfg_q.end_month   <= btda_pkg::RstEndMonth;
      cfg_q.end_day     <= btda_pkg::RstEndDay;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/btda_adjust.sv
module btda_adjust (
  input  btda_pkg::bcd_t  raw_i,
  input  btda_pkg::cfg_t  cfg_i,
  output btda_pkg::time_t res_o
);

  logic [7:0] sec, mnt, hr, wd, dy, mo, yd;
  logic [7:0] hr_inc, wd_inc, dy_inc, mo_inc, mlen;
  logic [11:0] yr;
  logic       in_win, apply, wrap;

  always_comb begin
    sec = btda_pkg::bcd_to_bin(raw_i.second);
    mnt = btda_pkg::bcd_to_bin(raw_i.minute);
    hr  = btda_pkg::bcd_to_bin(raw_i.hour);
    wd  = btda_pkg::bcd_to_bin(raw_i.weekday);
    dy  = btda_pkg::bcd_to_bin(raw_i.day);
    mo  = btda_pkg::bcd_to_bin(raw_i.month);
    yd  = btda_pkg::bcd_to_bin(raw_i.year);
    yr  = btda_pkg::YearBase + {4'b0000, yd};

    // window test on the values before any carry
    in_win = (mo > {4'b0000, cfg_i.start_month} && mo < {4'b0000, cfg_i.end_month})
          || (mo == {4'b0000, cfg_i.start_month} && dy >= {3'b000, cfg_i.start_day})
          || (mo == {4'b0000, cfg_i.end_month} && dy < {3'b000, cfg_i.end_day});
    apply  = cfg_i.dst_enable && in_win;

    hr_inc = hr + 8'd1;
    wd_inc = wd + 8'd1;
    dy_inc = dy + 8'd1;
    mo_inc = mo + 8'd1;
    mlen   = btda_pkg::month_len(yd, mo);
    wrap   = apply && (hr_inc >= btda_pkg::HoursPerDay);

    res_o.second       = sec;
    res_o.minute       = mnt;
    res_o.hour         = apply ? hr_inc : hr;
    res_o.weekday      = wd;
    res_o.day_of_month = dy;
    res_o.month        = mo;
    res_o.year         = yr;

    if (wrap) begin
      res_o.hour    = 8'd0;
      res_o.weekday = (wd_inc > btda_pkg::DaysPerWeek) ? 8'd1 : wd_inc;
      if (dy_inc > mlen) begin
        res_o.day_of_month = 8'd1;
        if (mo_inc > btda_pkg::MonthsPerYear) begin
          res_o.month = 8'd1;
          res_o.year  = yr + 12'd1;
        end else begin
          res_o.month = mo_inc;
        end
      end else begin
        res_o.day_of_month = dy_inc;
      end
    end
  end

endmodule

### rtl/bcd_time_dst_adjust.sv
// Decodes the seven BCD timekeeping bytes of a real-time clock into binary
// fields and a full year (2000 + two-digit year), then adds one hour when
// daylight saving is enabled and the date lies in the configured window,
// carrying a wrapped hour into weekday, day, month and year with Gregorian
// month lengths. Nibbles above 9 are decoded without a check. The block takes
// one transfer per cycle unless the input is stalled; each result passes
// through the input register and then the result register, with the decode
// and carry logic between them. A stalled output only stops the input once
// both registers are full. Configuration writes take effect on the next cycle
// and should only be made while no transfer is in flight.
module bcd_time_dst_adjust (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [btda_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [btda_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    bcd_second_i,
  input  logic [7:0]                    bcd_minute_i,
  input  logic [7:0]                    bcd_hour_i,
  input  logic [7:0]                    bcd_weekday_i,
  input  logic [7:0]                    bcd_day_i,
  input  logic [7:0]                    bcd_month_i,
  input  logic [7:0]                    bcd_year_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    second_o,
  output logic [7:0]                    minute_o,
  output logic [7:0]                    hour_o,
  output logic [7:0]                    weekday_o,
  output logic [7:0]                    day_of_month_o,
  output logic [7:0]                    month_o,
  output logic [11:0]                   year_o
);

  btda_pkg::cfg_t  cfg;
  btda_pkg::bcd_t  raw_d, raw_q;
  btda_pkg::time_t res_d, res_q;
  logic            raw_valid_q, res_valid_q;
  logic            res_adv, raw_adv;

  btda_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  btda_adjust u_adjust (
    .raw_i (raw_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  // result register loads when empty or its transfer completes
  assign res_adv    = !res_valid_q || !out_stall_i;
  assign raw_adv    = !raw_valid_q || res_adv;
  assign in_stall_o = !raw_adv;

  assign raw_d = '{second:  bcd_second_i,
                   minute:  bcd_minute_i,
                   hour:    bcd_hour_i,
                   weekday: bcd_weekday_i,
                   day:     bcd_day_i,
                   month:   bcd_month_i,
                   year:    bcd_year_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (raw_adv) begin
        raw_valid_q <= in_valid_i;
      end
      if (res_adv) begin
        res_valid_q <= raw_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_adv && in_valid_i) begin
      raw_q <= raw_d;
    end
    if (res_adv && raw_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign second_o       = res_q.second;
  assign minute_o       = res_q.minute;
  assign hour_o         = res_q.hour;
  assign weekday_o      = res_q.weekday;
  assign day_of_month_o = res_q.day_of_month;
  assign month_o        = res_q.month;
  assign year_o         = res_q.year;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (raw_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_item_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (raw_valid_q && res_adv) |=> out_valid_o)
    else $error("item in input register lost");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= 12'd2000 && year_o <= 12'd2166))
    else $error("year out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result changed");

endmodule
